// ===== hdl/drjm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drjm_pkg
// shared types, widths and constants of the delta-r jet matcher
// ----------------------------------------------------------------------------
package drjm_pkg;

  // field widths
  localparam int ReqW     = 2;
  localparam int SlotW    = 2;
  localparam int EtaW     = 14;
  localparam int PhiW     = 13;
  localparam int DistW    = 27;
  localparam int IdxW     = 7;
  localparam int TotW     = 32;
  localparam int CfgIdxW  = 1;

  // internal arithmetic widths
  localparam int DeW      = EtaW + 1;     // eta difference
  localparam int DphW     = PhiW + 1;     // raw phi difference
  localparam int DpW      = PhiW + 2;     // folded phi difference, signed
  localparam int SqW      = 2 * DeW;      // one square
  localparam int SumW     = SqW + 1;      // sum of two squares

  localparam int NumRefs  = 4;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);

  // angles, LSB 2^-10 rad
  localparam int PiQ      = 3217;
  localparam int TwoPiQ   = 6434;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // configuration
  localparam logic [CfgIdxW-1:0] CFG_MATCH_RADIUS = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ISO_RADIUS   = 1'd1;
  localparam logic [DistW-1:0]   MatchRadiusRst   = 27'd94372;
  localparam logic [DistW-1:0]   IsoRadiusRst     = 27'd10486;

  localparam int MaxJetsDef = 128;

  // request codes on the input channel
  localparam logic [ReqW-1:0] REQ_LOAD  = 2'd0;
  localparam logic [ReqW-1:0] REQ_JET   = 2'd1;
  localparam logic [ReqW-1:0] REQ_CLOSE = 2'd2;

  // reference slots
  localparam logic [SlotW-1:0] SLOT_B    = 2'd0;
  localparam logic [SlotW-1:0] SLOT_BBAR = 2'd1;
  localparam logic [SlotW-1:0] SLOT_MUM  = 2'd2;
  localparam logic [SlotW-1:0] SLOT_MUP  = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_JET   = 2'd1,
    OP_CLOSE = 2'd2
  } op_e;

  // one classified request as it sits in the queue
  typedef struct packed {
    op_e                     op;
    logic [SlotW-1:0]        slot;
    logic signed [EtaW-1:0]  eta;
    logic signed [PhiW-1:0]  phi;
  } item_t;

  // queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // control carried along the back pipeline
  typedef struct packed {
    logic            vld;
    op_e             op;
    logic            drop;
    logic [IdxW-1:0] idx;
  } stg_t;

endpackage

`default_nettype wire

// ===== hdl/delta_r_jet_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// delta_r_jet_matcher
// nearest-jet matching by squared delta-r to b and bbar, muon isolated
// ----------------------------------------------------------------------------
//
//   channel   handshake                  payload
//   -------   -------------------------  -------------------------------------
//   in        in_valid_i / in_ready_o    req_type, ref_slot, eta, phi
//   out       out_valid_o / out_ready_i  indices, distances, flags, total
//   cfg       cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// one request is taken per cycle while the fifo is not full; the back pipeline
// has four stages (diff and phi fold, squares, sum and saturate, search update)
// fed from a 4-entry fifo; a close passes the fifo and s1, s2, s3 on its
// way to the result register, which frees the pipeline as it drains
// reset clears references, search state, counters and all valid flags
// a held result stalls the back only when the next close reaches the end;
// the fifo then fills and in_ready_o drops
//
module delta_r_jet_matcher #(
  parameter int MAX_JETS = drjm_pkg::MaxJetsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [drjm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [drjm_pkg::DistW-1:0]        cfg_data_i,
  // request channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [drjm_pkg::ReqW-1:0]         req_type_i,
  input  wire logic [drjm_pkg::SlotW-1:0]        ref_slot_i,
  input  wire logic signed [drjm_pkg::EtaW-1:0]  eta_i,
  input  wire logic signed [drjm_pkg::PhiW-1:0]  phi_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [drjm_pkg::IdxW-1:0]              b_jet_index_o,
  output logic [drjm_pkg::IdxW-1:0]              bbar_jet_index_o,
  output logic [drjm_pkg::DistW-1:0]             b_dist_sq_o,
  output logic [drjm_pkg::DistW-1:0]             bbar_dist_sq_o,
  output logic                                   same_jet_o,
  output logic                                   pair_matched_o,
  output logic [drjm_pkg::TotW-1:0]              coincide_total_o
);
  import drjm_pkg::*;

  // configuration registers
  logic [DistW-1:0] match_radius_q, iso_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_radius_q <= MatchRadiusRst;
      iso_radius_q   <= IsoRadiusRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MATCH_RADIUS: match_radius_q <= cfg_data_i;
        CFG_ISO_RADIUS:   iso_radius_q   <= cfg_data_i;
        default:          match_radius_q <= match_radius_q;
      endcase
    end
  end

  // front to queue to back
  logic   push, pop;
  item_t  push_item, pop_item;
  qstat_t qstat;

  drjm_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .ref_slot_i (ref_slot_i),
    .eta_i      (eta_i),
    .phi_i      (phi_i),
    .q_full_i   (qstat.full),
    .push_o     (push),
    .item_o     (push_item)
  );

  drjm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .qstat_o     (qstat)
  );

  drjm_back #(
    .MAX_JETS (MAX_JETS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (qstat.empty),
    .item_i            (pop_item),
    .pop_o             (pop),
    .match_radius_sq_i (match_radius_q),
    .iso_radius_sq_i   (iso_radius_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .b_jet_index_o     (b_jet_index_o),
    .bbar_jet_index_o  (bbar_jet_index_o),
    .b_dist_sq_o       (b_dist_sq_o),
    .bbar_dist_sq_o    (bbar_dist_sq_o),
    .same_jet_o        (same_jet_o),
    .pair_matched_o    (pair_matched_o),
    .coincide_total_o  (coincide_total_o)
  );

endmodule

`default_nettype wire

// ===== hdl/drjm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drjm_front
// accepts requests, decodes the request code and drops unused codes
// ----------------------------------------------------------------------------
module drjm_front (
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [drjm_pkg::ReqW-1:0]     req_type_i,
  input  wire logic [drjm_pkg::SlotW-1:0]    ref_slot_i,
  input  wire logic signed [drjm_pkg::EtaW-1:0] eta_i,
  input  wire logic signed [drjm_pkg::PhiW-1:0] phi_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output drjm_pkg::item_t                    item_o
);
  import drjm_pkg::*;

  logic known;

  always_comb begin
    known       = 1'b1;
    item_o.op   = OP_LOAD;
    item_o.slot = ref_slot_i;
    item_o.eta  = eta_i;
    item_o.phi  = phi_i;
    case (req_type_i)
      REQ_LOAD:  item_o.op = OP_LOAD;
      REQ_JET:   item_o.op = OP_JET;
      REQ_CLOSE: item_o.op = OP_CLOSE;
      default:   known = 1'b0;  // unused code, taken and discarded
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o && known;

endmodule

`default_nettype wire

// ===== hdl/drjm_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drjm_queue
// short fifo between the front and the back pipeline
// ----------------------------------------------------------------------------
module drjm_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire drjm_pkg::item_t push_item_i,
  input  wire logic            pop_i,
  output drjm_pkg::item_t      pop_item_o,
  output drjm_pkg::qstat_t     qstat_o
);
  import drjm_pkg::*;

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign qstat_o.full  = (count_q == (QPtrW+1)'(QDepth));
  assign qstat_o.empty = (count_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign pop_item_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (QPtrW+1)'(1);
        2'b01:   count_q <= count_q - (QPtrW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/drjm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drjm_back
// distance pipeline, nearest-jet search and result register
// ----------------------------------------------------------------------------
module drjm_back #(
  parameter int MAX_JETS = drjm_pkg::MaxJetsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_empty_i,
  input  wire drjm_pkg::item_t             item_i,
  output logic                             pop_o,
  input  wire logic [drjm_pkg::DistW-1:0]  match_radius_sq_i,
  input  wire logic [drjm_pkg::DistW-1:0]  iso_radius_sq_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [drjm_pkg::IdxW-1:0]        b_jet_index_o,
  output logic [drjm_pkg::IdxW-1:0]        bbar_jet_index_o,
  output logic [drjm_pkg::DistW-1:0]       b_dist_sq_o,
  output logic [drjm_pkg::DistW-1:0]       bbar_dist_sq_o,
  output logic                             same_jet_o,
  output logic                             pair_matched_o,
  output logic [drjm_pkg::TotW-1:0]        coincide_total_o
);
  import drjm_pkg::*;

  localparam int CntW = $clog2(MAX_JETS + 1);

  // references
  logic signed [EtaW-1:0] ref_eta_q [NumRefs];
  logic signed [PhiW-1:0] ref_phi_q [NumRefs];

  logic [CntW-1:0] jet_cnt_q;

  // pipeline registers
  stg_t                   s1_q, s2_q, s3_q;
  stg_t                   s1_d;
  logic signed [DeW-1:0]  de_q  [NumRefs];
  logic signed [DpW-1:0]  dp_q  [NumRefs];
  logic signed [DeW-1:0]  de_d  [NumRefs];
  logic signed [DpW-1:0]  dp_d  [NumRefs];
  logic [SqW-1:0]         esq_q [NumRefs];
  logic [SqW-1:0]         psq_q [NumRefs];
  logic [DistW-1:0]       dist_q [NumRefs];

  // search state
  logic [DistW-1:0] best_b_dist_q, best_bbar_dist_q;
  logic [IdxW-1:0]  best_b_idx_q, best_bbar_idx_q;
  logic [TotW-1:0]  coinc_q;

  logic adv, fire_close, fire_jet, eligible, same, pair;
  logic [TotW-1:0] coinc_d;

  // stall only when a close sits at the end with the result register held
  assign adv   = !(s3_q.vld && (s3_q.op == OP_CLOSE) && out_valid_o && !out_ready_i);
  assign pop_o = adv && !q_empty_i;

  // first stage: differences and phi fold
  always_comb begin
    logic signed [DphW-1:0] dph;
    logic [DphW-1:0]        dabs;
    s1_d.vld  = pop_o;
    s1_d.op   = item_i.op;
    s1_d.drop = (item_i.op == OP_JET) && (jet_cnt_q >= CntW'(MAX_JETS));
    s1_d.idx  = IdxW'(jet_cnt_q);
    for (int k = 0; k < NumRefs; k++) begin
      de_d[k] = DeW'(item_i.eta) - DeW'(ref_eta_q[k]);
      dph     = DphW'(item_i.phi) - DphW'(ref_phi_q[k]);
      dabs    = dph[DphW-1] ? DphW'(-dph) : DphW'(dph);
      if (dabs > DphW'(PiQ)) begin
        dp_d[k] = DpW'(TwoPiQ) - $signed({1'b0, dabs});
      end else begin
        dp_d[k] = $signed({1'b0, dabs});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumRefs; k++) begin
        ref_eta_q[k] <= '0;
        ref_phi_q[k] <= '0;
      end
      jet_cnt_q <= '0;
    end else if (pop_o) begin
      case (item_i.op)
        OP_LOAD: begin
          ref_eta_q[item_i.slot] <= item_i.eta;
          ref_phi_q[item_i.slot] <= item_i.phi;
        end
        OP_JET: begin
          if (!s1_d.drop) jet_cnt_q <= jet_cnt_q + CntW'(1);
        end
        OP_CLOSE: jet_cnt_q <= '0;
        default: jet_cnt_q <= jet_cnt_q;
      endcase
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (adv) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  // datapath: squares, then sum and saturate
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumRefs; k++) begin
        de_q[k]  <= de_d[k];
        dp_q[k]  <= dp_d[k];
        esq_q[k] <= SqW'($signed(SqW'(de_q[k])) * $signed(SqW'(de_q[k])));
        psq_q[k] <= SqW'($signed(SqW'(dp_q[k])) * $signed(SqW'(dp_q[k])));
        if ((SumW'(esq_q[k]) + SumW'(psq_q[k])) > SumW'(DistMax)) begin
          dist_q[k] <= DistMax;
        end else begin
          dist_q[k] <= DistW'(SumW'(esq_q[k]) + SumW'(psq_q[k]));
        end
      end
    end
  end

  // last stage: search update and close
  assign fire_jet   = adv && s3_q.vld && (s3_q.op == OP_JET) && !s3_q.drop;
  assign fire_close = adv && s3_q.vld && (s3_q.op == OP_CLOSE);
  assign eligible   = (dist_q[SLOT_MUM] > iso_radius_sq_i) ||
                      (dist_q[SLOT_MUP] > iso_radius_sq_i);
  assign same       = (best_b_idx_q == best_bbar_idx_q);
  assign pair       = !same && (best_b_dist_q < match_radius_sq_i) &&
                      (best_bbar_dist_q < match_radius_sq_i);
  assign coinc_d    = (same && (coinc_q != '1)) ? coinc_q + TotW'(1) : coinc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_b_dist_q    <= DistMax;
      best_bbar_dist_q <= DistMax;
      best_b_idx_q     <= '0;
      best_bbar_idx_q  <= '0;
      coinc_q          <= '0;
    end else if (fire_close) begin
      best_b_dist_q    <= DistMax;
      best_bbar_dist_q <= DistMax;
      best_b_idx_q     <= '0;
      best_bbar_idx_q  <= '0;
      coinc_q          <= coinc_d;
    end else if (fire_jet && eligible) begin
      if (dist_q[SLOT_B] < best_b_dist_q) begin
        best_b_dist_q <= dist_q[SLOT_B];
        best_b_idx_q  <= s3_q.idx;
      end
      if (dist_q[SLOT_BBAR] < best_bbar_dist_q) begin
        best_bbar_dist_q <= dist_q[SLOT_BBAR];
        best_bbar_idx_q  <= s3_q.idx;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fire_close) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_close) begin
      b_jet_index_o    <= best_b_idx_q;
      bbar_jet_index_o <= best_bbar_idx_q;
      b_dist_sq_o      <= best_b_dist_q;
      bbar_dist_sq_o   <= best_bbar_dist_q;
      same_jet_o       <= same;
      pair_matched_o   <= pair;
      coincide_total_o <= coinc_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_delta_r_jet_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_delta_r_jet_matcher
// self-checking bench: directed event table, then random events in phases
// that step through several radius settings. every close result is checked
// field by field against a typed-in value or a cycle-free nearest-jet model.
// ----------------------------------------------------------------------------
module tb_delta_r_jet_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import drjm_pkg::*;

  // request code the block must ignore
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;

  localparam int ResetCycles   = 9;
  localparam int SettleCycles  = 20;
  localparam int DrainCycles   = 20;
  localparam int HoldCycles    = 300;   // long receiver hold-off
  localparam int WatchdogLimit = 4000;  // no config, request or result moving
  localparam int PhaseItems    = 170;
  localparam int NumPhases     = 5;

  // one close result as seen on the output ports
  typedef struct packed {
    logic [IdxW-1:0]  b_idx;
    logic [IdxW-1:0]  bbar_idx;
    logic [DistW-1:0] b_dist;
    logic [DistW-1:0] bbar_dist;
    logic             same;
    logic             pair;
    logic [TotW-1:0]  total;
  } match_res_t;

  // one row of the directed table; chk marks a result typed in by hand
  typedef struct packed {
    logic [ReqW-1:0]        req;
    logic [SlotW-1:0]       slot;
    logic signed [EtaW-1:0] eta;
    logic signed [PhiW-1:0] phi;
    logic                   chk;
    match_res_t             res;
  } stim_row_t;

  localparam match_res_t ResNone = '0;
  // empty search right after reset: no jet, both indices 0, so same jet
  localparam match_res_t ResAfterReset =
    '{7'd0, 7'd0, DistMax, DistMax, 1'b1, 1'b0, 32'd1};
  // jets sitting exactly on b and bbar: distances 0, pair matched
  localparam match_res_t ResBothExact =
    '{7'd1, 7'd2, 27'd0, 27'd0, 1'b0, 1'b1, 32'd1};

  localparam stim_row_t DirRows [24] = '{
    // close on an empty event straight after reset
    '{REQ_CLOSE,  SLOT_B,    14'sd0,     13'sd0,     1'b1, ResAfterReset},
    // references at the range extremes, both muons at the origin
    '{REQ_LOAD,   SLOT_B,    14'sd4096,  13'sd3217,  1'b0, ResNone},
    '{REQ_LOAD,   SLOT_BBAR, -14'sd4096, -13'sd3217, 1'b0, ResNone},
    '{REQ_LOAD,   SLOT_MUM,  14'sd0,     13'sd0,     1'b0, ResNone},
    '{REQ_LOAD,   SLOT_MUP,  14'sd0,     13'sd0,     1'b0, ResNone},
    // jet 0 on both muons is not isolated, jets 1 and 2 hit b and bbar
    '{REQ_JET,    SLOT_B,    14'sd0,     13'sd0,     1'b0, ResNone},
    '{REQ_JET,    SLOT_B,    14'sd4096,  13'sd3217,  1'b0, ResNone},
    '{REQ_JET,    SLOT_B,    -14'sd4096, -13'sd3217, 1'b0, ResNone},
    '{REQ_CLOSE,  SLOT_B,    14'sd0,     13'sd0,     1'b1, ResBothExact},
    // unused code with most-negative payload, must leave no trace
    '{REQ_UNUSED, SLOT_MUP,  -14'sd8192, -13'sd4096, 1'b0, ResNone},
    // phi fold across pi, then an exact tie where the first jet must win
    '{REQ_JET,    SLOT_B,    14'sd4096,  -13'sd3217, 1'b0, ResNone},
    '{REQ_JET,    SLOT_B,    14'sd4096,  -13'sd3217, 1'b0, ResNone},
    // field extremes outside the physical range, distances saturate
    '{REQ_JET,    SLOT_BBAR, -14'sd8192, -13'sd4096, 1'b0, ResNone},
    '{REQ_JET,    SLOT_MUP,  14'sd8191,  13'sd4095,  1'b0, ResNone},
    '{REQ_CLOSE,  SLOT_MUM,  14'sd8191,  13'sd4095,  1'b0, ResNone},
    // isolation is an or: close to mu- only still passes
    '{REQ_LOAD,   SLOT_MUM,  14'sd1000,  13'sd1000,  1'b0, ResNone},
    '{REQ_LOAD,   SLOT_MUP,  -14'sd1000, -13'sd1000, 1'b0, ResNone},
    '{REQ_JET,    SLOT_B,    14'sd1000,  13'sd1000,  1'b0, ResNone},
    // both muons on the jet now, so it is dropped
    '{REQ_LOAD,   SLOT_MUP,  14'sd1000,  13'sd1000,  1'b0, ResNone},
    '{REQ_JET,    SLOT_B,    14'sd1000,  13'sd1050,  1'b0, ResNone},
    // phi out of range: the fold goes negative and is squared signed
    '{REQ_LOAD,   SLOT_B,    14'sd0,     13'sd4095,  1'b0, ResNone},
    '{REQ_JET,    SLOT_BBAR, 14'sd0,     -13'sd4096, 1'b0, ResNone},
    '{REQ_CLOSE,  SLOT_BBAR, 14'sd0,     13'sd0,     1'b0, ResNone},
    // back-to-back close, empty search again
    '{REQ_CLOSE,  SLOT_B,    14'sd0,     13'sd0,     1'b0, ResNone}
  };

  // dut signals, all inputs known from time zero
  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i        = CFG_MATCH_RADIUS;
  logic [DistW-1:0]       cfg_data_i       = '0;
  logic                   in_valid_i       = 1'b0;
  logic                   in_ready_o;
  logic [ReqW-1:0]        req_type_i       = REQ_LOAD;
  logic [SlotW-1:0]       ref_slot_i       = SLOT_B;
  logic signed [EtaW-1:0] eta_i            = '0;
  logic signed [PhiW-1:0] phi_i            = '0;
  logic                   out_valid_o;
  logic                   out_ready_i      = 1'b0;
  logic [IdxW-1:0]        b_jet_index_o;
  logic [IdxW-1:0]        bbar_jet_index_o;
  logic [DistW-1:0]       b_dist_sq_o;
  logic [DistW-1:0]       bbar_dist_sq_o;
  logic                   same_jet_o;
  logic                   pair_matched_o;
  logic [TotW-1:0]        coincide_total_o;

  // hand-typed expectation riding along with the request on the bus
  logic       typed_chk = 1'b0;
  match_res_t typed_res = ResNone;

  // model state, reset values given at declaration (reset happens once)
  logic signed [EtaW-1:0] anchor_eta [NumRefs] = '{default: '0};
  logic signed [PhiW-1:0] anchor_phi [NumRefs] = '{default: '0};
  logic [DistW-1:0]       match_radius   = MatchRadiusRst;
  logic [DistW-1:0]       iso_radius     = IsoRadiusRst;
  logic [DistW-1:0]       best_b_dist    = DistMax;
  logic [DistW-1:0]       best_bbar_dist = DistMax;
  logic [IdxW-1:0]        best_b_idx     = '0;
  logic [IdxW-1:0]        best_bbar_idx  = '0;
  int unsigned            jets_seen      = 0;
  logic [TotW-1:0]        coincide_cnt   = '0;

  match_res_t  pending_matches [$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;

  // references as the stimulus side last loaded them, to aim jets
  logic signed [EtaW-1:0] aim_eta [NumRefs] = '{default: '0};
  logic signed [PhiW-1:0] aim_phi [NumRefs] = '{default: '0};

  // receiver hold-off handshake between the driver and the result sink
  bit hold_off_req = 1'b0;
  bit hold_active  = 1'b0;

  delta_r_jet_matcher dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .ref_slot_i       (ref_slot_i),
    .eta_i            (eta_i),
    .phi_i            (phi_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .b_jet_index_o    (b_jet_index_o),
    .bbar_jet_index_o (bbar_jet_index_o),
    .b_dist_sq_o      (b_dist_sq_o),
    .bbar_dist_sq_o   (bbar_dist_sq_o),
    .same_jet_o       (same_jet_o),
    .pair_matched_o   (pair_matched_o),
    .coincide_total_o (coincide_total_o)
  );

  always #10 clk_i = ~clk_i;

  // squared delta-r to one stored reference, phi folded about pi,
  // saturated to the 27 bit range
  function automatic logic [DistW-1:0] delta_r_sq(logic signed [EtaW-1:0] eta,
                                                  logic signed [PhiW-1:0] phi,
                                                  logic [SlotW-1:0] s);
    int     de;
    int     dp;
    longint sq;
    de = int'(eta) - int'(anchor_eta[s]);
    dp = int'(phi) - int'(anchor_phi[s]);
    if (dp < 0) dp = -dp;
    // out-of-range phi can make this negative, the square takes care of it
    if (dp > PiQ) dp = TwoPiQ - dp;
    sq = longint'(de) * de + longint'(dp) * dp;
    return (sq > longint'(DistMax)) ? DistMax : DistW'(sq);
  endfunction

  // advance the search by one request; returns 1 when a close yields a result
  function automatic bit apply_request(logic [ReqW-1:0] req, logic [SlotW-1:0] slot,
                                       logic signed [EtaW-1:0] eta,
                                       logic signed [PhiW-1:0] phi,
                                       output match_res_t res);
    logic [DistW-1:0] d_b;
    logic [DistW-1:0] d_bbar;
    logic [DistW-1:0] d_mum;
    logic [DistW-1:0] d_mup;
    bit               isolated;
    bit               same;
    res = ResNone;
    case (req)
      REQ_LOAD: begin
        anchor_eta[slot] = eta;
        anchor_phi[slot] = phi;
      end
      REQ_JET: begin
        // jets past the per-event limit are dropped without a count
        if (jets_seen < MaxJetsDef) begin
          d_b    = delta_r_sq(eta, phi, SLOT_B);
          d_bbar = delta_r_sq(eta, phi, SLOT_BBAR);
          d_mum  = delta_r_sq(eta, phi, SLOT_MUM);
          d_mup  = delta_r_sq(eta, phi, SLOT_MUP);
          isolated = (d_mum > iso_radius) || (d_mup > iso_radius);
          // strict less-than: on a tie the earlier jet stays
          if (isolated && d_b < best_b_dist) begin
            best_b_dist = d_b;
            best_b_idx  = IdxW'(jets_seen);
          end
          if (isolated && d_bbar < best_bbar_dist) begin
            best_bbar_dist = d_bbar;
            best_bbar_idx  = IdxW'(jets_seen);
          end
          jets_seen++;
        end
      end
      REQ_CLOSE: begin
        same = (best_b_idx == best_bbar_idx);
        if (same && coincide_cnt != '1) coincide_cnt++;
        res = '{best_b_idx, best_bbar_idx, best_b_dist, best_bbar_dist, same,
                !same && best_b_dist < match_radius && best_bbar_dist < match_radius,
                coincide_cnt};
        // per-event search restarts, references stay
        best_b_dist    = DistMax;
        best_bbar_dist = DistMax;
        best_b_idx     = '0;
        best_bbar_idx  = '0;
        jets_seen      = 0;
        return 1'b1;
      end
      default: ;  // unused code, no effect at all
    endcase
    return 1'b0;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // monitor: config writes, taken requests and taken results, all sampled
  // at the edge at which they take effect
  always @(posedge clk_i) begin
    match_res_t res;
    match_res_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MATCH_RADIUS: match_radius = cfg_data_i;
          CFG_ISO_RADIUS:   iso_radius   = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_matches.size() == 0) begin
          $display("%0t: result with no close pending, b_idx %0d bbar_idx %0d",
                   $time, b_jet_index_o, bbar_jet_index_o);
          mismatches++;
        end else begin
          want = pending_matches.pop_front();
          check_field("b_jet_index",    64'(want.b_idx),     64'(b_jet_index_o));
          check_field("bbar_jet_index", 64'(want.bbar_idx),  64'(bbar_jet_index_o));
          check_field("b_dist_sq",      64'(want.b_dist),    64'(b_dist_sq_o));
          check_field("bbar_dist_sq",   64'(want.bbar_dist), 64'(bbar_dist_sq_o));
          check_field("same_jet",       64'(want.same),      64'(same_jet_o));
          check_field("pair_matched",   64'(want.pair),      64'(pair_matched_o));
          check_field("coincide_total", 64'(want.total),     64'(coincide_total_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (apply_request(req_type_i, ref_slot_i, eta_i, phi_i, res))
          pending_matches.push_back(typed_chk ? typed_res : res);
      end
    end
  end

  // watchdog: nothing moving for too long means the block hung
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no request moved for %0d cycles, %0d results still due",
               $time, idle_cycles, pending_matches.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // gap length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [EtaW-1:0] rand_eta();
    // now and then raw bits, well outside the physical range
    if ($urandom_range(0, 7) == 0) return EtaW'($urandom);
    return EtaW'(int'($urandom_range(0, 8192)) - 4096);
  endfunction

  function automatic logic signed [PhiW-1:0] rand_phi();
    if ($urandom_range(0, 7) == 0) return PhiW'($urandom);
    return PhiW'(int'($urandom_range(0, 6434)) - 3217);
  endfunction

  // offer one request and hold it until taken, then maybe pause
  task automatic send(logic [ReqW-1:0] req, logic [SlotW-1:0] slot,
                      logic signed [EtaW-1:0] eta, logic signed [PhiW-1:0] phi,
                      logic chk, match_res_t res);
    int unsigned gap;
    in_valid_i <= 1'b1;
    req_type_i <= req;
    ref_slot_i <= slot;
    eta_i      <= eta;
    phi_i      <= phi;
    typed_chk  <= chk;
    typed_res  <= res;
    do @(posedge clk_i); while (!in_ready_o);
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // radii change only with the block idle: all results in, last jets drained
  task automatic set_radii(logic [DistW-1:0] match_sq, logic [DistW-1:0] iso_sq);
    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MATCH_RADIUS;
    cfg_data_i <= match_sq;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ISO_RADIUS;
    cfg_data_i <= iso_sq;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // one event: reload most references, stream jets aimed near them, close.
  // a tenth of the unforced calls send one request of raw noise instead
  task automatic random_event(int unsigned forced_jets, inout int unsigned sent);
    logic [ReqW-1:0]        noise_req;
    logic signed [EtaW-1:0] e;
    logic signed [PhiW-1:0] p;
    int unsigned            njets;
    int unsigned            near;
    int unsigned            s;
    int unsigned            j;
    if (forced_jets == 0 && $urandom_range(0, 9) == 0) begin
      noise_req = ReqW'($urandom);
      send(noise_req, SlotW'($urandom), EtaW'($urandom), PhiW'($urandom), 1'b0, ResNone);
      if (noise_req != REQ_UNUSED) sent++;
      return;
    end
    for (s = 0; s < NumRefs; s++) begin
      if ($urandom_range(0, 7) != 0) begin
        e = rand_eta();
        p = rand_phi();
        aim_eta[s] = e;
        aim_phi[s] = p;
        send(REQ_LOAD, SlotW'(s), e, p, 1'b0, ResNone);
        sent++;
      end
    end
    if (forced_jets != 0) njets = forced_jets;
    else if ($urandom_range(0, 14) == 0) njets = $urandom_range(16, 48);
    else njets = $urandom_range(0, 8);
    for (j = 0; j < njets; j++) begin
      near = $urandom_range(0, 9);
      if (near < 8) begin
        // within about the match radius of one reference, muons included
        s = 32'((near < 3) ? SLOT_B : (near < 6) ? SLOT_BBAR :
                (near == 6) ? SLOT_MUM : SLOT_MUP);
        e = EtaW'(int'(aim_eta[s]) + int'($urandom_range(0, 700)) - 350);
        p = PhiW'(int'(aim_phi[s]) + int'($urandom_range(0, 700)) - 350);
      end else begin
        e = rand_eta();
        p = rand_phi();
      end
      send(REQ_JET, SlotW'($urandom), e, p, 1'b0, ResNone);
      sent++;
    end
    // sometimes no close, so the next event's jets pile onto this search
    if (forced_jets != 0 || $urandom_range(0, 19) != 0) begin
      send(REQ_CLOSE, SlotW'($urandom), EtaW'($urandom), PhiW'($urandom), 1'b0, ResNone);
      sent++;
    end
  endtask

  // result sink: random ready with bursts and stalls, plus one long hold-off
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_active  = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active  = 1'b0;
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      stall = idle_len();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // request driver
  initial begin : request_driver
    int unsigned sent;
    int unsigned target;
    int unsigned ph;
    int unsigned k;
    sent = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset radii
    foreach (DirRows[i])
      send(DirRows[i].req, DirRows[i].slot, DirRows[i].eta, DirRows[i].phi,
           DirRows[i].chk, DirRows[i].res);

    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: ;  // reset radii
        // zero radii: any nonzero muon distance isolates, nothing pairs
        1: set_radii('0, '0);
        // all-ones radii: no jet can ever be isolated
        2: set_radii(DistMax, DistMax);
        3: set_radii(DistW'($urandom_range(1000, 2000000)),
                     DistW'($urandom_range(0, 200000)));
        // distinct jets pair below saturation; only jets on both muons drop
        default: set_radii(DistMax, '0);
      endcase
      if (ph == 3) begin
        // back-pressure: results pile up while the sink holds off,
        // the fifo fills and the input stalls
        hold_off_req = 1'b1;
        while (!hold_active) @(posedge clk_i);
        for (k = 0; k < 60; k++) begin
          if ($urandom_range(0, 3) == 0)
            send(REQ_JET, SlotW'($urandom), rand_eta(), rand_phi(), 1'b0, ResNone);
          else
            send(REQ_CLOSE, SlotW'($urandom), rand_eta(), rand_phi(), 1'b0, ResNone);
          sent++;
        end
      end
      // one event longer than the jet limit
      if (ph == 4) random_event(MaxJetsDef + 12, sent);
      target = sent + PhaseItems;
      while (sent < target) random_event(0, sent);
    end

    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== delta_r_jet_matcher.f =====
hdl/drjm_pkg.sv
hdl/drjm_front.sv
hdl/drjm_queue.sv
hdl/drjm_back.sv
hdl/delta_r_jet_matcher.sv
tb/sv/tb_delta_r_jet_matcher.sv
